// ----- rtl/task_ready_queue_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TASK_READY_QUEUE_TOP_ASSERT_SVH
`define TASK_READY_QUEUE_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define TRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/trq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package trq_pkg;

  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic capture;  // latch request, evaluate match vector
    logic apply;    // update cells, count and result register
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/trq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output trq_pkg::cmd_t cmd
);
  import trq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/trq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trq_datapath #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  trq_pkg::cmd_t                cmd,
  input  logic                         cfg_we,
  input  logic                         cfg_mode,
  input  logic [trq_pkg::OP_W-1:0]     operation,
  input  logic [trq_pkg::ID_W-1:0]     task_id,
  input  logic [trq_pkg::PRIO_W-1:0]   task_priority,
  output logic [trq_pkg::ST_W-1:0]     status,
  output logic [trq_pkg::ID_W-1:0]     out_task_id,
  output logic [trq_pkg::PRIO_W-1:0]   out_priority,
  output logic [trq_pkg::OCC_W-1:0]    occupancy
);
  import trq_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [ID_W-1:0]      cell_task [MAX_TASKS];
  logic [PRIO_W-1:0]    cell_prio [MAX_TASKS];
  logic [CW-1:0]        count, count_next;
  logic                 mode;
  logic [OP_W-1:0]      op_q;
  logic [ID_W-1:0]      task_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [MAX_TASKS-1:0] match_q, match_next;
  logic [MAX_TASKS-1:0] first, ge, tail_oh, ins_oh, shift_up;
  logic                 any, full, do_ins, do_del;
  logic [ST_W-1:0]      status_next;

  // isolate first match; ge marks it and everything behind it
  assign first    = match_q & (~match_q + 1'b1);
  assign ge       = ~(first - 1'b1);
  assign any      = |match_q;
  assign full     = (count == CW'(MAX_TASKS));
  assign ins_oh   = any ? first : tail_oh;
  assign shift_up = ge & ~first;
  assign do_ins   = cmd.apply && (op_q == OP_INSERT) && !full;
  assign do_del   = cmd.apply && ((op_q == OP_REMOVE) || (op_q == OP_POP)) && any;

  genvar g;
  for (g = 0; g < MAX_TASKS; g++) begin : g_cell
    logic [ID_W-1:0]   up_task, dn_task;
    logic [PRIO_W-1:0] up_prio, dn_prio;
    logic              live;

    assign live       = (CW'(g) < count);
    assign tail_oh[g] = (CW'(g) == count);

    always_comb begin
      case (operation)
        OP_INSERT: match_next[g] = live && mode && (task_priority > cell_prio[g]);
        OP_REMOVE: match_next[g] = live && (task_id == cell_task[g]);
        OP_POP:    match_next[g] = live && (g == 0);
        default:   match_next[g] = 1'b0;
      endcase
    end

    if (g > 0) begin : g_up
      assign up_task = cell_task[g-1];
      assign up_prio = cell_prio[g-1];
    end else begin : g_head
      assign up_task = task_q;
      assign up_prio = prio_q;
    end

    if (g < MAX_TASKS - 1) begin : g_dn
      assign dn_task = cell_task[g+1];
      assign dn_prio = cell_prio[g+1];
    end else begin : g_last
      assign dn_task = cell_task[g];
      assign dn_prio = cell_prio[g];
    end

    always_ff @(posedge clk) begin
      if (do_ins && ins_oh[g]) begin
        cell_task[g] <= task_q;
        cell_prio[g] <= prio_q;
      end else if (do_ins && shift_up[g]) begin
        cell_task[g] <= up_task;
        cell_prio[g] <= up_prio;
      end else if (do_del && ge[g]) begin
        cell_task[g] <= dn_task;
        cell_prio[g] <= dn_prio;
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (op_q) inside
      OP_INSERT: begin
        if (full) status_next = ST_FULL;
        else      count_next  = count + 1'b1;
      end
      OP_REMOVE, OP_POP: begin
        if (any) count_next  = count - 1'b1;
        else     status_next = ST_MISS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mode  <= 1'b0;
    end else begin
      if (cfg_we)    mode  <= cfg_mode;
      if (cmd.apply) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      task_q  <= task_id;
      prio_q  <= task_priority;
      match_q <= match_next;
    end
    if (cmd.apply) begin
      status    <= status_next;
      occupancy <= OCC_W'(count_next);
      if ((op_q == OP_POP) && any) begin
        out_task_id  <= cell_task[0];
        out_priority <= cell_prio[0];
      end else begin
        out_task_id  <= '0;
        out_priority <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/task_ready_queue_top.sv -----
// A result is registered in the apply state after its request is accepted,
// once the output register is free. No new request is accepted until the
// previous one is applied; the cell chain is compared on accept, shifted on apply.
// A finished result waits in the output register while the next request enters.
// Reset (rst, synchronous, active high) empties the queue and selects FIFO mode.
`timescale 1ns / 1ps
`default_nettype none
module task_ready_queue_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         queue_mode,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [trq_pkg::OP_W-1:0]     operation,
  input  logic [trq_pkg::ID_W-1:0]     task_id,
  input  logic [trq_pkg::PRIO_W-1:0]   task_priority,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [trq_pkg::ST_W-1:0]     status,
  output logic [trq_pkg::ID_W-1:0]     out_task_id,
  output logic [trq_pkg::PRIO_W-1:0]   out_priority,
  output logic [trq_pkg::OCC_W-1:0]    occupancy
);
  import trq_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  trq_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_mode      (queue_mode),
    .operation     (operation),
    .task_id       (task_id),
    .task_priority (task_priority),
    .status        (status),
    .out_task_id   (out_task_id),
    .out_priority  (out_priority),
    .occupancy     (occupancy)
  );

endmodule
`default_nettype wire

// ----- rtl/trq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "task_ready_queue_top_assert.svh"
module trq_checker #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [trq_pkg::ST_W-1:0]     status,
  input  logic [trq_pkg::ID_W-1:0]     out_task_id,
  input  logic [trq_pkg::PRIO_W-1:0]   out_priority,
  input  logic [trq_pkg::OCC_W-1:0]    occupancy
);
  import trq_pkg::*;

  `TRQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(out_task_id) && $stable(occupancy),
    "result changed while stalled")

  `TRQ_ASSERT_ALWAYS(a_occ_bound, !out_valid || (MAX_TASKS > 31) || (occupancy <= MAX_TASKS),
    "occupancy above queue depth")

  `TRQ_ASSERT_ALWAYS(a_pop_ok, !out_valid || (out_task_id == '0 && out_priority == '0)
    || status == ST_OK, "popped task reported with failing status")

  `TRQ_ASSERT_NEXT(a_two_cycle, in_valid && in_ready, !in_ready,
    "request accepted on back-to-back cycles")

endmodule

bind task_ready_queue_top trq_checker #(.MAX_TASKS(MAX_TASKS)) u_trq_checker (.*);
`default_nettype wire
